>>> hdl/pbm_pkg.sv
package pbm_pkg;

   // Field widths
   localparam int ANGLE_W     = 17;
   localparam int THR_W       = 12;
   localparam int PULSE_W     = 11;
   localparam int GAIN_W      = 16;
   localparam int WIN_W       = 16;
   localparam int RATE_W      = 10;
   localparam int ERR_W       = ANGLE_W + 1;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // Fixed point and limits
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int GAIN_FRAC_BITS      = 8;
   localparam int PID_LIMIT           = 1000;
   localparam int PULSE_MIN           = 1000;
   localparam int PULSE_MAX           = 2000;

   // Register reset values
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd358;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd466;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd266;
   localparam logic [WIN_W-1:0]  INTEG_WIN_RST  = 16'd2048;
   localparam logic [RATE_W-1:0] LOOP_RATE_RST  = 10'd250;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_INTEG_WIN  = 3'd3,
      CSR_LOOP_RATE  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_SEL_P,
      MUL_SEL_I,
      MUL_SEL_DD,
      MUL_SEL_D
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ_upd;
      logic        sum_en;
      logic        out_load;
   } pbm_cmd_type;

   typedef struct packed {
      logic out_free;
   } pbm_status_type;

endpackage

>>> hdl/pbm_req_if.sv
interface pbm_req_if import pbm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  setpoint_angle;
   logic signed [ANGLE_W-1:0]  measured_angle;
   logic        [THR_W-1:0]    base_throttle;
   logic                       motors_enabled;

   modport source (
      output valid, setpoint_angle, measured_angle, base_throttle, motors_enabled,
      input  ready
   );
   modport sink (
      input  valid, setpoint_angle, measured_angle, base_throttle, motors_enabled,
      output ready
   );
endinterface

>>> hdl/pbm_rsp_if.sv
interface pbm_rsp_if import pbm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic        [PULSE_W-1:0]  right_pulse;
   logic        [PULSE_W-1:0]  left_pulse;
   logic signed [PULSE_W-1:0]  correction;

   modport source (
      output valid, right_pulse, left_pulse, correction,
      input  ready
   );
   modport sink (
      input  valid, right_pulse, left_pulse, correction,
      output ready
   );
endinterface

>>> hdl/pbm_ctrl.sv
module pbm_ctrl import pbm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  pbm_status_type status,
   output pbm_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_DD,
      ST_MUL_D,
      ST_SUM,
      ST_MIX
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = MUL_SEL_P;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_P;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_I;
            state_in    = ST_MUL_DD;
         end
         ST_MUL_DD: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_SEL_DD;
            cmd.integ_upd = 1'b1;
            state_in      = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_D;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_MIX;
         end
         ST_MIX: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/pbm_datapath.sv
module pbm_datapath import pbm_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pbm_cmd_type               cmd,
   output pbm_status_type            status,
   input  logic signed [ANGLE_W-1:0] req_setpoint_angle,
   input  logic signed [ANGLE_W-1:0] req_measured_angle,
   input  logic [THR_W-1:0]          req_base_throttle,
   input  logic                      req_motors_enabled,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [PULSE_W-1:0]        rsp_right_pulse,
   output logic [PULSE_W-1:0]        rsp_left_pulse,
   output logic signed [PULSE_W-1:0] rsp_correction
);

   localparam int FB      = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int P_W     = ERR_W + GAIN_W;
   localparam int DD_W    = DIFF_W + GAIN_W;
   localparam int D_W     = DD_W + RATE_W + 1;
   localparam int MUL_A_W = DD_W + 1;
   localparam int MUL_B_W = GAIN_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int INT_W   = 32;
   localparam int ISUM_W  = INT_W + 4;
   localparam int SUM_W   = D_W + 3;
   localparam int MIX_W   = THR_W + 2;

   localparam logic signed [INT_W-1:0]  ILIM    = INT_W'(PID_LIMIT * (2 ** FB));
   localparam logic signed [ISUM_W-1:0] ILIM_X  = ISUM_W'(ILIM);
   localparam logic signed [SUM_W-1:0]  SUM_LIM = SUM_W'(PID_LIMIT);
   localparam logic signed [MIX_W-1:0]  MIX_MIN = MIX_W'(PULSE_MIN);
   localparam logic signed [MIX_W-1:0]  MIX_MAX = MIX_W'(PULSE_MAX);

   // configuration registers
   logic signed [GAIN_W-1:0] kp_ff, kp_in;
   logic signed [GAIN_W-1:0] ki_ff, ki_in;
   logic signed [GAIN_W-1:0] kd_ff, kd_in;
   logic [WIN_W-1:0]         win_ff, win_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;

   // per-request and loop state
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W-1:0]  last_err_ff, last_err_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [THR_W-1:0]         thr_ff, thr_in;
   logic                     en_ff, en_in;
   logic                     lt_ff, lt_in;
   logic                     gt_ff, gt_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [P_W-1:0]    kierr_ff, kierr_in;
   logic signed [DD_W-1:0]   dd_ff, dd_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic signed [INT_W-1:0]  integ_ff, integ_in;
   logic signed [PULSE_W-1:0] pid_ff, pid_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]        right_ff, right_in;
   logic [PULSE_W-1:0]        left_ff, left_in;
   logic signed [PULSE_W-1:0] corr_ff, corr_in;

   logic signed [ERR_W-1:0]   err_now;
   logic [ERR_W-1:0]          mag_now;
   logic [ERR_W-1:0]          win_ext;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [ISUM_W-1:0]  isum;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   shifted;
   logic signed [MIX_W-1:0]   thr_s;
   logic signed [MIX_W-1:0]   pid_s;
   logic signed [MIX_W-1:0]   right_raw;
   logic signed [MIX_W-1:0]   left_raw;

   assign err_now = ERR_W'(req_setpoint_angle) - ERR_W'(req_measured_angle);
   assign mag_now = err_now[ERR_W-1] ? ERR_W'(-err_now) : ERR_W'(err_now);
   assign win_ext = ERR_W'(win_ff);

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SEL_P: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(kp_ff);
         end
         MUL_SEL_I: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(ki_ff);
         end
         MUL_SEL_DD: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = MUL_B_W'(kd_ff);
         end
         MUL_SEL_D: begin
            mul_a = MUL_A_W'(dd_ff);
            mul_b = MUL_B_W'($signed({1'b0, rate_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign isum    = ISUM_W'(integ_ff) + ISUM_W'(kierr_ff);
   assign sum     = SUM_W'(p_ff) + SUM_W'(integ_ff) + SUM_W'(d_ff);
   assign shifted = sum >>> FB;

   assign thr_s     = $signed({2'b00, thr_ff});
   assign pid_s     = MIX_W'(pid_ff);
   assign right_raw = thr_s + pid_s;
   assign left_raw  = thr_s - pid_s;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      kp_in       = kp_ff;
      ki_in       = ki_ff;
      kd_in       = kd_ff;
      win_in      = win_ff;
      rate_in     = rate_ff;
      err_in      = err_ff;
      last_err_in = last_err_ff;
      diff_in     = diff_ff;
      thr_in      = thr_ff;
      en_in       = en_ff;
      lt_in       = lt_ff;
      gt_in       = gt_ff;
      p_in        = p_ff;
      kierr_in    = kierr_ff;
      dd_in       = dd_ff;
      d_in        = d_ff;
      integ_in    = integ_ff;
      pid_in      = pid_ff;
      rsp_valid_in = rsp_valid_ff;
      right_in    = right_ff;
      left_in     = left_ff;
      corr_in     = corr_ff;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:  kp_in   = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_INTEG_GAIN: ki_in   = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_DERIV_GAIN: kd_in   = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_INTEG_WIN:  win_in  = csr_wdata[WIN_W-1:0];
            CSR_LOOP_RATE:  rate_in = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         err_in      = err_now;
         diff_in     = DIFF_W'(err_now) - DIFF_W'(last_err_ff);
         last_err_in = err_now;
         thr_in      = req_base_throttle;
         en_in       = req_motors_enabled;
         lt_in       = mag_now < win_ext;
         gt_in       = mag_now > win_ext;
      end

      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            MUL_SEL_P:  p_in     = prod[P_W-1:0];
            MUL_SEL_I:  kierr_in = prod[P_W-1:0];
            MUL_SEL_DD: dd_in    = prod[DD_W-1:0];
            MUL_SEL_D:  d_in     = prod[D_W-1:0];
            default: ;
         endcase
      end

      // accumulate inside the window, clear outside, hold on the edge
      if (cmd.integ_upd) begin
         if (lt_ff) begin
            priority if (isum > ILIM_X)       integ_in = ILIM;
            else if (isum < -ILIM_X)          integ_in = -ILIM;
            else                              integ_in = isum[INT_W-1:0];
         end else if (gt_ff) begin
            integ_in = '0;
         end
      end

      if (cmd.sum_en) begin
         priority if (shifted > SUM_LIM)      pid_in = PULSE_W'(PID_LIMIT);
         else if (shifted < -SUM_LIM)         pid_in = PULSE_W'(-PID_LIMIT);
         else                                 pid_in = shifted[PULSE_W-1:0];
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         corr_in      = pid_ff;
         priority if (!en_ff)                 right_in = PULSE_W'(PULSE_MIN);
         else if (right_raw < MIX_MIN)        right_in = PULSE_W'(PULSE_MIN);
         else if (right_raw > MIX_MAX)        right_in = PULSE_W'(PULSE_MAX);
         else                                 right_in = right_raw[PULSE_W-1:0];
         priority if (!en_ff)                 left_in = PULSE_W'(PULSE_MIN);
         else if (left_raw < MIX_MIN)         left_in = PULSE_W'(PULSE_MIN);
         else if (left_raw > MIX_MAX)         left_in = PULSE_W'(PULSE_MAX);
         else                                 left_in = left_raw[PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= PROP_GAIN_RST;
         ki_ff        <= INTEG_GAIN_RST;
         kd_ff        <= DERIV_GAIN_RST;
         win_ff       <= INTEG_WIN_RST;
         rate_ff      <= LOOP_RATE_RST;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         win_ff       <= win_in;
         rate_ff      <= rate_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      thr_ff   <= thr_in;
      en_ff    <= en_in;
      lt_ff    <= lt_in;
      gt_ff    <= gt_in;
      p_ff     <= p_in;
      kierr_ff <= kierr_in;
      dd_ff    <= dd_in;
      d_ff     <= d_in;
      pid_ff   <= pid_in;
      right_ff <= right_in;
      left_ff  <= left_in;
      corr_ff  <= corr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_right_pulse = right_ff;
   assign rsp_left_pulse  = left_ff;
   assign rsp_correction  = corr_ff;

endmodule

>>> hdl/pid_balance_two_motor_mixer_unit.sv
// Sequence: an accepted request steps through the four products of the shared
// multiplier (P, I, D difference, D rate scaling) in turn, then the sum and the
// mix, which waits for the output register; the next request is taken only in idle.
// A response waiting in the output register does not block the next request.
// Reset (synchronous, active high): restore gain defaults, clear the integral
// and last error, drop any pending response.
module pid_balance_two_motor_mixer_unit import pbm_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   pbm_req_if.sink                req_if,
   pbm_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   pbm_cmd_type    cmd;
   pbm_status_type status;
   logic           ctrl_ready;

   // Sequencer: accept a request in idle, step the shared multiplier,
   // then sum, clamp and mix into the output register.
   pbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_if.ready = ctrl_ready;

   // Datapath: error, gains, integral state, multiplier and output stage.
   pbm_datapath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_setpoint_angle (req_if.setpoint_angle),
      .req_measured_angle (req_if.measured_angle),
      .req_base_throttle  (req_if.base_throttle),
      .req_motors_enabled (req_if.motors_enabled),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_if.valid),
      .rsp_right_pulse    (rsp_if.right_pulse),
      .rsp_left_pulse     (rsp_if.left_pulse),
      .rsp_correction     (rsp_if.correction)
   );

endmodule

>>> hdl/pbm_checker.sv
module pbm_checker import pbm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [PULSE_W-1:0]        right_pulse,
   input logic [PULSE_W-1:0]        left_pulse,
   input logic signed [PULSE_W-1:0] correction
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> right_pulse >= PULSE_W'(PULSE_MIN) && right_pulse <= PULSE_W'(PULSE_MAX)
                 && left_pulse >= PULSE_W'(PULSE_MIN) && left_pulse <= PULSE_W'(PULSE_MAX))
      else $error("motor pulse out of range");

   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> correction >= PULSE_W'(-PID_LIMIT) && correction <= PULSE_W'(PID_LIMIT))
      else $error("correction out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pid_balance_two_motor_mixer_unit pbm_checker u_pbm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .right_pulse (rsp_if.right_pulse),
   .left_pulse  (rsp_if.left_pulse),
   .correction  (rsp_if.correction)
);

>>> tb/sv/pid_balance_two_motor_mixer_unit_tb.sv
`timescale 1ns / 1ps

module pid_balance_two_motor_mixer_unit_tb;
   import pbm_pkg::*;

   localparam int     CLK_PERIOD     = 20;
   localparam int     FRAC_SUM       = ANGLE_FRAC_BITS_DEF + GAIN_FRAC_BITS;
   localparam longint INTEG_LIMIT    = longint'(PID_LIMIT) <<< FRAC_SUM;
   localparam int     ITEMS_PER_SET  = 200;
   localparam int     SETTING_COUNT  = 7;
   localparam int     DRAIN_CYCLES   = 12;
   localparam int     WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic [PULSE_W-1:0] right_pulse;
      logic [PULSE_W-1:0] left_pulse;
      logic [PULSE_W-1:0] correction;
   } motor_pulses_type;

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Shadow of the controller: gain registers, integral and previous error,
   // plus the pulses still owed by the block in request order.
   class mixer_checker;
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic        [WIN_W-1:0]  integ_window;
      logic        [RATE_W-1:0] loop_rate;
      longint                   integral_acc;
      longint                   prev_error;
      motor_pulses_type         expected_pulses[$];
      int                       mismatches;

      function new();
         prop_gain    = PROP_GAIN_RST;
         integ_gain   = INTEG_GAIN_RST;
         deriv_gain   = DERIV_GAIN_RST;
         integ_window = INTEG_WIN_RST;
         loop_rate    = LOOP_RATE_RST;
         integral_acc = 0;
         prev_error   = 0;
         mismatches   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         unique case (idx)
            CSR_PROP_GAIN:  prop_gain    = value;
            CSR_INTEG_GAIN: integ_gain   = value;
            CSR_DERIV_GAIN: deriv_gain   = value;
            CSR_INTEG_WIN:  integ_window = value;
            CSR_LOOP_RATE:  loop_rate    = value[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      // One control tick: P, windowed integral, rate-scaled derivative, mix.
      function void predict_tick(logic signed [ANGLE_W-1:0] setpoint,
                                 logic signed [ANGLE_W-1:0] measured,
                                 logic [THR_W-1:0] throttle, logic enabled);
         longint           err, mag, p_term, d_term, pid, right, left;
         motor_pulses_type want;
         err    = longint'(setpoint) - longint'(measured);
         mag    = (err < 0) ? -err : err;
         p_term = longint'(prop_gain) * err;
         if (mag < longint'(integ_window))
            integral_acc = clip(integral_acc + longint'(integ_gain) * err,
                                -INTEG_LIMIT, INTEG_LIMIT);
         else if (mag > longint'(integ_window))
            integral_acc = 0;
         d_term = longint'(deriv_gain) * (err - prev_error) * longint'(loop_rate);
         pid    = clip((p_term + integral_acc + d_term) >>> FRAC_SUM,
                       -PID_LIMIT, PID_LIMIT);
         right  = clip(longint'(throttle) + pid, PULSE_MIN, PULSE_MAX);
         left   = clip(longint'(throttle) - pid, PULSE_MIN, PULSE_MAX);
         if (!enabled) begin
            right = PULSE_MIN;
            left  = PULSE_MIN;
         end
         prev_error       = err;
         want.right_pulse = right[PULSE_W-1:0];
         want.left_pulse  = left[PULSE_W-1:0];
         want.correction  = pid[PULSE_W-1:0];
         expected_pulses.push_back(want);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pulses(motor_pulses_type got);
         motor_pulses_type want;
         if (expected_pulses.size() == 0) begin
            $display("%0t: response with no request outstanding: right %0d left %0d corr %0d",
                     $time, got.right_pulse, got.left_pulse, $signed(got.correction));
            mismatches++;
            return;
         end
         want = expected_pulses.pop_front();
         compare_field("right_pulse", want.right_pulse, got.right_pulse);
         compare_field("left_pulse", want.left_pulse, got.left_pulse);
         compare_field("correction", longint'($signed(want.correction)),
                       longint'($signed(got.correction)));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   csr_index_type            csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   pbm_req_if req_bus ();
   pbm_rsp_if rsp_bus ();

   mixer_checker sb = new();

   bit steady;          // suppress idling on both sides while set
   int walk_err;        // slowly drifting error for tracking ticks
   int rsp_stall;
   int idle_cycles;

   pid_balance_two_motor_mixer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Gap length for either side: mostly none, often a few cycles, now and
   // then a long one.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Signed random value in [-span, span], as a 16-bit register word.
   function automatic logic [CSR_DATA_W-1:0] mild_gain(int span);
      return CSR_DATA_W'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Response side: check on the handshake, then pick the next ready level.
   // Signals are read before this edge's updates land, so ordering is safe.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_pulses('{rsp_bus.right_pulse, rsp_bus.left_pulse, rsp_bus.correction});
      if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // Watchdog: abort when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("pid_balance_two_motor_mixer_unit_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request after a random gap and hold it until it is taken.
   // Keep valid high across back-to-back requests; drop it only for a gap.
   task automatic send_request(input logic signed [ANGLE_W-1:0] sp,
                               input logic signed [ANGLE_W-1:0] ms,
                               input logic [THR_W-1:0] thr, input logic en);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.setpoint_angle <= sp;
      req_bus.measured_angle <= ms;
      req_bus.base_throttle  <= thr;
      req_bus.motors_enabled <= en;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.predict_tick(sp, ms, thr, en);
   endtask

   // Random tick: most often a drifting error so the integral builds up, then
   // ticks right at the window edge, ticks across the stated range and raw
   // bit patterns.
   task automatic send_random_item();
      int                        kind;
      int                        err;
      logic signed [ANGLE_W-1:0] sp, ms;
      logic        [THR_W-1:0]   thr;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         walk_err = walk_err + int'($urandom_range(0, 128)) - 64;
         if (walk_err > 3000) walk_err = 3000;
         if (walk_err < -3000) walk_err = -3000;
         sp = ANGLE_W'(int'($urandom_range(0, 16384)) - 8192);
         ms = ANGLE_W'(int'(sp) - walk_err);
      end else if (kind < 65) begin
         err = int'(sb.integ_window) + int'($urandom_range(0, 2)) - 1;
         if ($urandom_range(0, 1) == 1) err = -err;
         sp = ANGLE_W'(int'($urandom_range(0, 40000)) - 20000);
         ms = ANGLE_W'(int'(sp) - err);
      end else if (kind < 85) begin
         sp = ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
         ms = ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
      end else begin
         sp = ANGLE_W'($urandom);
         ms = ANGLE_W'($urandom);
      end
      thr = ($urandom_range(0, 9) < 7) ? THR_W'($urandom_range(800, 2200))
                                       : THR_W'($urandom);
      send_request(sp, ms, thr, $urandom_range(0, 9) != 0);
   endtask

   // Drop valid and wait until every owed response is back: block is idle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.expected_pulses.size() != 0) @(posedge clock);
   endtask

   // Write all five registers on consecutive edges; call only when idle.
   task automatic load_settings(input logic [CSR_DATA_W-1:0] kp,
                                input logic [CSR_DATA_W-1:0] ki,
                                input logic [CSR_DATA_W-1:0] kd,
                                input logic [CSR_DATA_W-1:0] win,
                                input logic [CSR_DATA_W-1:0] rate_word);
      logic [CSR_DATA_W-1:0] vals [0:4];
      csr_index_type         idx;
      vals = '{kp, ki, kd, win, rate_word};
      idx  = idx.first();
      repeat (idx.num()) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[idx];
         @(posedge clock);
         sb.write_reg(idx, vals[idx]);
         idx = idx.next();
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      // Drive every request input to a known level and hold reset;
      // the response side sets ready from the first edge on.
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.setpoint_angle <= '0;
      req_bus.measured_angle <= '0;
      req_bus.base_throttle  <= '0;
      req_bus.motors_enabled <= 1'b0;
      csr_wr_en              <= 1'b0;
      csr_index              <= CSR_PROP_GAIN;
      csr_wdata              <= '0;
      steady                  = 1'b0;
      walk_err                = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks with the reset gains.
      send_request(0, 0, 1500, 1);              // no error at all
      send_request(256, 0, 1500, 1);            // small error, integral builds
      send_request(2048, 0, 1500, 1);           // error equal to window: hold
      send_request(0, 2049, 1500, 1);           // just past window: clear
      send_request(0, 2047, 1500, 1);           // just inside, negative
      send_request(46080, -46080, 1500, 1);     // stated extremes, pid clamps
      send_request(-46080, 46080, 1500, 0);     // motors off
      send_request(65535, -65536, 4095, 1);     // widest positive error
      send_request(-65536, 65535, 0, 1);        // widest negative error
      send_request(-65536, -65536, 4095, 0);
      send_request(65535, 65535, 0, 1);
      send_request(0, 0, 1000, 1);              // throttle at pulse floor
      send_request(0, 0, 2000, 1);              // throttle at pulse ceiling
      settle();

      // Extreme gains, widest window, rate word with junk above bit 9.
      load_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
      send_request(46080, 0, 1500, 1);          // integral saturates at once
      send_request(46080, 0, 1500, 1);          // and stays pinned
      send_request(-46080, 0, 1500, 1);
      send_request(0, 0, 1500, 1);
      settle();

      // Zero rate kills the derivative; zero window clears on any error.
      load_settings(16'd0, INTEG_GAIN_RST, 16'h7FFF, 16'd0, 16'd0);
      send_request(512, 0, 1500, 1);
      send_request(0, 0, 1500, 1);
      send_request(-512, 256, 1500, 1);
      settle();

      // Random ticks under a series of gain settings.
      for (int p = 0; p < SETTING_COUNT; p++) begin
         case (p)
            0: load_settings(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST,
                             INTEG_WIN_RST, CSR_DATA_W'(LOOP_RATE_RST));
            1: load_settings(16'h8000, 16'h8000, 16'h8000, 16'd46080, 16'd1000);
            2: load_settings(mild_gain(2048), mild_gain(512), mild_gain(512),
                             CSR_DATA_W'($urandom_range(0, 8192)),
                             CSR_DATA_W'($urandom_range(1, 1000)));
            3: load_settings(16'h7FFF, 16'd1, 16'd0, 16'hFFFF, 16'd1);
            4: load_settings(mild_gain(8192), mild_gain(64), mild_gain(64),
                             CSR_DATA_W'($urandom_range(1, 4096)),
                             {6'($urandom), RATE_W'($urandom_range(1, 1000))});
            5: load_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                             CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                             CSR_DATA_W'($urandom));
            default: load_settings(16'd0, 16'd0, 16'd0, CSR_DATA_W'($urandom), 16'd0);
         endcase
         walk_err = 0;
         for (int i = 0; i < ITEMS_PER_SET; i++) begin
            // Run the first stretch of each setting without any idling.
            steady = (i < 30);
            send_random_item();
         end
         steady = 1'b0;
         settle();
      end

      // Let any stray response surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_pulses.size() == 0)
         $display("pid_balance_two_motor_mixer_unit_tb OK");
      else
         $display("pid_balance_two_motor_mixer_unit_tb NOT OK");
      $finish;
   end

endmodule
